>>> rtl/taie_pkg.sv
// Package: opcodes, fault codes and widths for the three-address executor.
`default_nettype none
package taie_pkg;
  localparam int unsigned DataDepthDef = 256;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned LineDepthDef = 1024;

  localparam int unsigned OpW    = 5;
  localparam int unsigned AddrW  = 8;
  localparam int unsigned ImmW   = 32;
  localparam int unsigned LineW  = 10;
  localparam int unsigned FaultW = 2;
  localparam int unsigned PrintW = 32;

  typedef enum logic [OpW-1:0] {
    ADD  = 5'd0,  SUB  = 5'd1,  MUL  = 5'd2,  DIV  = 5'd3,
    INF  = 5'd4,  EQU  = 5'd5,  SUP  = 5'd6,  AND  = 5'd7,
    OR   = 5'd8,  JMF  = 5'd9,  AFC  = 5'd10, COP  = 5'd11,
    COPA = 5'd12, COPB = 5'd13, JMP  = 5'd14, PRI  = 5'd15,
    CALL = 5'd16, RET  = 5'd17, NOP  = 5'd18
  } op_e;

  typedef enum logic [FaultW-1:0] {
    F_NONE = 2'd0, F_OPCODE = 2'd1, F_DIVZERO = 2'd2, F_RANGE = 2'd3
  } fault_e;

  localparam logic CfgStartLine = 1'b0;
  localparam logic CfgEndLine   = 1'b1;

  // Divider handshake.
  typedef struct packed {
    logic start;
  } div_req_t;
endpackage
`default_nettype wire

>>> rtl/taie_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module taie_div #(
  parameter int unsigned DataWidth = taie_pkg::DataWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire taie_pkg::div_req_t   req_i,
  input  wire logic [DataWidth-1:0] dividend_i,
  input  wire logic [DataWidth-1:0] divisor_i,
  output logic                      done_o,
  output logic      [DataWidth-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(DataWidth + 1);

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth:0]   rem_q, rem_d;
  logic [DataWidth-1:0] dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic                 done_q, done_d;
  logic [DataWidth:0]   shifted, trial;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q[DataWidth-1:0], quo_q[DataWidth-1]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataWidth);
      quo_d  = dividend_i[DataWidth-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d  = divisor_i[DataWidth-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_d  = '0;
      neg_d  = dividend_i[DataWidth-1] ^ divisor_i[DataWidth-1];
    end else if (busy_q) begin
      if (!trial[DataWidth]) begin
        rem_d = trial;
        quo_d = {quo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DataWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule
`default_nettype wire

>>> rtl/three_address_instruction_executor_core.sv
// Top level: executes one memory-to-memory instruction per input transfer.
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    opcode, addresses, immediate, jump line
//  out       output     out_valid/out_stall  next line, halted, print, fault
//  cfg       input      cfg_we_i             cfg_idx_i, cfg_data_i
//
// One instruction at a time. Each one steps through accept, operand read,
// decide, execute and write back; COPB reads its pointer and source in the
// same round. COPA makes a pointer read then a dependent read, and DIV waits
// for the iterative divider; each read goes to the single synchronous memory
// (two read ports, one write port).
// Reset clears control and the program counter; the data memory is not cleared.
// A result waits in the output register while out_stall is high; the next
// instruction is still taken, but completes once that register frees or drains.
`default_nettype none
module three_address_instruction_executor_core #(
  parameter int unsigned DATA_DEPTH = taie_pkg::DataDepthDef,
  parameter int unsigned DATA_WIDTH = taie_pkg::DataWidthDef,
  parameter int unsigned LINE_DEPTH = taie_pkg::LineDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [taie_pkg::OpW-1:0]      opcode_i,
  input  wire logic [taie_pkg::AddrW-1:0]    dest_addr_i,
  input  wire logic [taie_pkg::AddrW-1:0]    src1_addr_i,
  input  wire logic [taie_pkg::AddrW-1:0]    src2_addr_i,
  input  wire logic signed [taie_pkg::ImmW-1:0] immediate_value_i,
  input  wire logic [taie_pkg::LineW-1:0]    jump_line_i,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [taie_pkg::LineW-1:0]    next_line_o,
  output logic                               halted_o,
  output logic                               print_valid_o,
  output logic      [taie_pkg::AddrW-1:0]    print_addr_o,
  output logic signed [taie_pkg::PrintW-1:0] print_value_o,
  output logic      [taie_pkg::FaultW-1:0]   fault_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [taie_pkg::LineW-1:0]    cfg_data_i
);
  localparam int unsigned AW  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(LINE_DEPTH);
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned FAW = taie_pkg::AddrW;

  localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2,
                         S_EXE = 3'd3, S_DIV = 3'd4;

  logic [DW-1:0] mem_q [DATA_DEPTH];
  logic [AW-1:0] ra_a, ra_b, wa;
  logic          re, we;
  logic [DW-1:0] rd_a_q, rd_b_q, wd;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) begin
      rd_a_q <= mem_q[ra_a];
      rd_b_q <= mem_q[ra_b];
    end
  end

  logic [2:0] st_q, st_d;
  logic [taie_pkg::OpW-1:0]   op_q;
  logic [FAW-1:0]             d_q, s1_q, s2_q;
  logic [DW-1:0]              imm_q;
  logic [LW-1:0]              jl_q, pc_q, pc_d;
  logic [LW-1:0]              end_q;
  logic [DW-1:0]              ptr_q;   // COPA pointer word
  logic                       ind_q;   // second read round done
  logic                       ov_q;
  logic [LW-1:0]              nl_q;
  logic                       hl_q, pv_q;
  logic [FAW-1:0]             pa_q;
  logic [taie_pkg::PrintW-1:0] pval_q;
  logic [taie_pkg::FaultW-1:0] flt_q;

  taie_pkg::div_req_t div_req;
  logic               div_done;
  logic [DW-1:0]      div_quo;

  taie_div #(.DataWidth(DW)) u_div (
    .clk_i, .rst_ni, .req_i(div_req), .dividend_i(rd_a_q), .divisor_i(rd_b_q),
    .done_o(div_done), .quotient_o(div_quo)
  );

  function automatic logic in_rng(input logic [FAW-1:0] a);
    return 32'(a) < DATA_DEPTH;
  endfunction
  function automatic logic ptr_ok(input logic [DW-1:0] p);
    return !p[DW-1] && (64'(p) < 64'(DATA_DEPTH));
  endfunction

  logic out_free, accept;
  assign out_free = !ov_q || !out_stall;
  assign in_stall = (st_q != S_IDLE);
  assign accept   = in_valid && !in_stall;

  logic signed [DW-1:0] a_s, b_s;
  logic [DW-1:0]        r;
  logic                 fin, wr, pvl;
  logic [LW-1:0]        nxt, inc;
  taie_pkg::fault_e     flt;
  logic                 rng_bad;

  assign a_s = rd_a_q;
  assign b_s = rd_b_q;
  assign inc = pc_q + 1'b1;

  always_comb begin
    st_d    = st_q;
    re      = 1'b0;
    ra_a    = AW'(s1_q);
    ra_b    = AW'(s2_q);
    we      = 1'b0;
    wa      = AW'(d_q);
    wd      = '0;
    r       = '0;
    wr      = 1'b0;
    pvl     = 1'b0;
    fin     = 1'b0;
    nxt     = inc;
    flt     = taie_pkg::F_NONE;
    div_req.start = 1'b0;
    rng_bad = 1'b0;
    unique case (st_q)
      S_IDLE: if (accept) st_d = S_RD1;
      S_RD1: begin
        re = 1'b1;
        if (op_q == taie_pkg::COPB) ra_b = AW'(d_q);
        st_d = S_RD2;
      end
      S_RD2: begin
        // second, dependent read for COPA
        if (!ind_q && op_q == taie_pkg::COPA) begin
          if (in_rng(d_q) && in_rng(s1_q) && ptr_ok(rd_a_q)) begin
            re   = 1'b1;
            ra_a = AW'(rd_a_q);
          end
          st_d = S_RD2;
        end else if (op_q == taie_pkg::DIV && rd_b_q != '0 && in_rng(d_q)
                     && in_rng(s1_q) && in_rng(s2_q)) begin
          div_req.start = 1'b1;
          st_d = S_DIV;
        end else begin
          st_d = S_EXE;
        end
      end
      S_DIV: if (div_done) st_d = S_EXE;
      S_EXE: begin
        if (out_free) begin
          fin = 1'b1;
          unique case (op_q)
            taie_pkg::ADD, taie_pkg::SUB, taie_pkg::MUL, taie_pkg::DIV,
            taie_pkg::INF, taie_pkg::EQU, taie_pkg::SUP, taie_pkg::AND,
            taie_pkg::OR: begin
              rng_bad = !in_rng(d_q) || !in_rng(s1_q) || !in_rng(s2_q);
              wr = 1'b1;
              unique case (op_q)
                taie_pkg::ADD: r = rd_a_q + rd_b_q;
                taie_pkg::SUB: r = rd_a_q - rd_b_q;
                taie_pkg::MUL: r = rd_a_q * rd_b_q;
                taie_pkg::DIV: begin
                  r = div_quo;
                  if (rd_b_q == '0) flt = taie_pkg::F_DIVZERO;
                end
                taie_pkg::INF: r = DW'(a_s < b_s);
                taie_pkg::EQU: r = DW'(rd_a_q == rd_b_q);
                taie_pkg::SUP: r = DW'(b_s < a_s);
                taie_pkg::AND: r = DW'(rd_a_q != '0 && rd_b_q != '0);
                default:       r = DW'(rd_a_q != '0 || rd_b_q != '0);
              endcase
            end
            taie_pkg::JMF: begin
              rng_bad = !in_rng(s1_q);
              if (rd_a_q != DW'(1)) nxt = jl_q;
            end
            taie_pkg::AFC: begin
              rng_bad = !in_rng(d_q);
              wr = 1'b1;
              r  = imm_q;
            end
            taie_pkg::COP: begin
              rng_bad = !in_rng(d_q) || !in_rng(s1_q);
              wr = 1'b1;
              r  = rd_a_q;
            end
            taie_pkg::COPA: begin
              rng_bad = !in_rng(d_q) || !in_rng(s1_q) || !ptr_ok(ptr_q);
              wr = 1'b1;
              r  = rd_a_q;
            end
            taie_pkg::COPB: begin
              // port b holds the target pointer, port a the source value
              rng_bad = !in_rng(d_q) || !in_rng(s1_q) || !ptr_ok(rd_b_q);
              wr = 1'b1;
              wa = AW'(rd_b_q);
              r  = rd_a_q;
            end
            taie_pkg::JMP: nxt = jl_q;
            taie_pkg::PRI: begin
              rng_bad = !in_rng(s1_q);
              pvl = 1'b1;
            end
            taie_pkg::CALL, taie_pkg::RET, taie_pkg::NOP: ;
            default: flt = taie_pkg::F_OPCODE;
          endcase
          if (rng_bad) flt = taie_pkg::F_RANGE;
          if (flt != taie_pkg::F_NONE) begin
            nxt = pc_q;
            wr  = 1'b0;
            pvl = 1'b0;
          end
          we   = wr;
          wd   = r;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (fin) pc_d = nxt;
    if (cfg_we_i && cfg_idx_i == taie_pkg::CfgStartLine) pc_d = LW'(cfg_data_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      pc_q  <= '0;
      end_q <= '0;
      ov_q  <= 1'b0;
      ind_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
      if (cfg_we_i && cfg_idx_i == taie_pkg::CfgEndLine) end_q <= LW'(cfg_data_i);
      if (fin) ov_q <= 1'b1;
      else if (!out_stall) ov_q <= 1'b0;
      if (accept) ind_q <= 1'b0;
      else if (st_q == S_RD2 && st_d == S_RD2) ind_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      d_q   <= dest_addr_i;
      s1_q  <= src1_addr_i;
      s2_q  <= src2_addr_i;
      imm_q <= DW'(immediate_value_i);
      jl_q  <= LW'(jump_line_i);
    end
    if (st_q == S_RD2 && st_d == S_RD2) ptr_q <= rd_a_q;
    if (fin) begin
      nl_q   <= nxt;
      hl_q   <= (flt != taie_pkg::F_NONE) || (nxt == end_q);
      pv_q   <= pvl;
      pa_q   <= pvl ? s1_q : '0;
      pval_q <= pvl ? taie_pkg::PrintW'(rd_a_q) : '0;
      flt_q  <= flt;
    end
  end

  assign out_valid     = ov_q;
  assign next_line_o   = taie_pkg::LineW'(nl_q);
  assign halted_o      = hl_q;
  assign print_valid_o = pv_q;
  assign print_addr_o  = pa_q;
  assign print_value_o = pval_q;
  assign fault_o       = flt_q;
endmodule
`default_nettype wire

>>> tb/sv/tb_three_address_instruction_executor_core.sv
// Testbench for the three-address instruction executor core.
`timescale 1ns / 100ps
`default_nettype none
module tb_three_address_instruction_executor_core;
  localparam int unsigned Words    = taie_pkg::DataDepthDef;
  localparam int unsigned DataW    = taie_pkg::DataWidthDef;
  localparam int unsigned OpW      = taie_pkg::OpW;
  localparam int unsigned AddrW    = taie_pkg::AddrW;
  localparam int unsigned ImmW     = taie_pkg::ImmW;
  localparam int unsigned LineW    = taie_pkg::LineW;
  localparam int unsigned FaultW   = taie_pkg::FaultW;
  localparam int unsigned PrintW   = taie_pkg::PrintW;
  localparam int unsigned LastOp   = (1 << OpW) - 1;
  localparam int unsigned NumPhase = 8;
  localparam int unsigned PerPhase = 225;
  localparam int unsigned LongHold = 300;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] dst;
    logic [AddrW-1:0] src1;
    logic [AddrW-1:0] src2;
    logic [ImmW-1:0]  imm;
    logic [LineW-1:0] jline;
  } instr_t;

  typedef struct {
    logic [LineW-1:0]  nline;
    logic              halt;
    logic              pvalid;
    logic [AddrW-1:0]  paddr;
    logic [PrintW-1:0] pvalue;
    logic [FaultW-1:0] flt;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OpW-1:0]    opcode_i = '0;
  logic [AddrW-1:0]  dest_addr_i = '0;
  logic [AddrW-1:0]  src1_addr_i = '0;
  logic [AddrW-1:0]  src2_addr_i = '0;
  logic [ImmW-1:0]   immediate_value_i = '0;
  logic [LineW-1:0]  jump_line_i = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [LineW-1:0]  next_line_o;
  logic              halted_o;
  logic              print_valid_o;
  logic [AddrW-1:0]  print_addr_o;
  logic [PrintW-1:0] print_value_o;
  logic [FaultW-1:0] fault_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = taie_pkg::CfgStartLine;
  logic [LineW-1:0]  cfg_data_i = '0;

  three_address_instruction_executor_core u_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .opcode_i, .dest_addr_i, .src1_addr_i, .src2_addr_i,
    .immediate_value_i, .jump_line_i,
    .out_valid, .out_stall,
    .next_line_o, .halted_o, .print_valid_o, .print_addr_o, .print_value_o, .fault_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow machine: data words, which of them hold a value, program counter
  // and the two line registers. Updated as instructions are queued, which is
  // safe since the block runs them strictly in order.
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] shadow_mem [Words];
  bit               word_set   [Words];
  logic [AddrW-1:0] set_addrs  [$];
  logic [LineW-1:0] shadow_pc;
  logic [LineW-1:0] stop_line;

  instr_t   pending_instrs [$];
  outcome_t expected_outcomes [$];

  int  mismatches = 0;
  bit  idle_en = 1'b1;
  int  long_hold_req = 0;     // raised by the sequencer
  int  long_hold_done = 0;    // served by the receiver

  function automatic bit ptr_valid(input logic [DataW-1:0] p);
    return !p[DataW-1] && (p < Words);
  endfunction

  function automatic logic [DataW-1:0] sdiv(input logic [DataW-1:0] a,
                                            input logic [DataW-1:0] b);
    logic [DataW-1:0] ma, mb, q;
    ma = a[DataW-1] ? -a : a;
    mb = b[DataW-1] ? -b : b;
    q  = ma / mb;
    return (a[DataW-1] != b[DataW-1]) ? -q : q;
  endfunction

  function automatic void store_word(input logic [AddrW-1:0] adr,
                                     input logic [DataW-1:0] val);
    shadow_mem[adr] = val;
    if (!word_set[adr]) begin
      word_set[adr] = 1'b1;
      set_addrs.push_back(adr);
    end
  endfunction

  // Executes one instruction on the shadow machine and returns its outcome.
  function automatic outcome_t run_instr(input instr_t x);
    outcome_t o;
    logic [DataW-1:0] a, b, r;
    logic [LineW-1:0] nxt;
    taie_pkg::fault_e f;
    bit wr;
    logic [AddrW-1:0] wa;
    a = shadow_mem[x.src1];
    b = shadow_mem[x.src2];
    r = '0;
    wr = 1'b0;
    wa = x.dst;
    f = taie_pkg::F_NONE;
    nxt = shadow_pc + 1'b1;
    o.pvalid = 1'b0;
    o.paddr = '0;
    o.pvalue = '0;
    case (x.op)
      taie_pkg::ADD: begin r = a + b; wr = 1'b1; end
      taie_pkg::SUB: begin r = a - b; wr = 1'b1; end
      taie_pkg::MUL: begin r = a * b; wr = 1'b1; end
      taie_pkg::DIV: begin
        if (b == '0) f = taie_pkg::F_DIVZERO;
        else begin r = sdiv(a, b); wr = 1'b1; end
      end
      taie_pkg::INF: begin r = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1'b1; end
      taie_pkg::EQU: begin r = (a == b) ? 1 : 0; wr = 1'b1; end
      taie_pkg::SUP: begin r = ($signed(a) > $signed(b)) ? 1 : 0; wr = 1'b1; end
      taie_pkg::AND: begin r = (a != 0 && b != 0) ? 1 : 0; wr = 1'b1; end
      taie_pkg::OR:  begin r = (a != 0 || b != 0) ? 1 : 0; wr = 1'b1; end
      taie_pkg::JMF: if (a != 1) nxt = x.jline;
      taie_pkg::AFC: begin r = x.imm; wr = 1'b1; end
      taie_pkg::COP: begin r = a; wr = 1'b1; end
      taie_pkg::COPA: begin
        if (!ptr_valid(a)) f = taie_pkg::F_RANGE;
        else begin r = shadow_mem[a[AddrW-1:0]]; wr = 1'b1; end
      end
      taie_pkg::COPB: begin
        if (!ptr_valid(shadow_mem[x.dst])) f = taie_pkg::F_RANGE;
        else begin r = a; wa = shadow_mem[x.dst][AddrW-1:0]; wr = 1'b1; end
      end
      taie_pkg::JMP: nxt = x.jline;
      taie_pkg::PRI: begin o.pvalid = 1'b1; o.paddr = x.src1; o.pvalue = a; end
      taie_pkg::CALL, taie_pkg::RET, taie_pkg::NOP: ;
      default: f = taie_pkg::F_OPCODE;
    endcase
    if (f != taie_pkg::F_NONE) begin
      nxt = shadow_pc;
      o.pvalid = 1'b0;
      o.paddr = '0;
      o.pvalue = '0;
    end else if (wr) begin
      store_word(wa, r);
    end
    shadow_pc = nxt;
    o.nline = nxt;
    o.halt = (f != taie_pkg::F_NONE) || (nxt == stop_line);
    o.flt = f;
    return o;
  endfunction

  // Never read a word that has not been written.
  function automatic bit reads_defined(input instr_t x);
    case (x.op)
      taie_pkg::ADD, taie_pkg::SUB, taie_pkg::MUL, taie_pkg::DIV, taie_pkg::INF,
      taie_pkg::EQU, taie_pkg::SUP, taie_pkg::AND, taie_pkg::OR:
        return word_set[x.src1] && word_set[x.src2];
      taie_pkg::JMF, taie_pkg::COP, taie_pkg::PRI: return word_set[x.src1];
      taie_pkg::COPA: return word_set[x.src1] &&
                             (!ptr_valid(shadow_mem[x.src1]) ||
                              word_set[shadow_mem[x.src1][AddrW-1:0]]);
      taie_pkg::COPB: return word_set[x.dst] && word_set[x.src1];
      default: return 1'b1;
    endcase
  endfunction

  function automatic void queue_instr(input logic [OpW-1:0] op, input int dst, input int s1,
                                      input int s2, input logic [ImmW-1:0] imm, input int jl);
    instr_t x;
    x.op = op;
    x.dst = AddrW'(dst);
    x.src1 = AddrW'(s1);
    x.src2 = AddrW'(s2);
    x.imm = imm;
    x.jline = LineW'(jl);
    pending_instrs.push_back(x);
    expected_outcomes.push_back(run_instr(x));
  endfunction

  function automatic logic [AddrW-1:0] any_set_addr();
    return set_addrs[$urandom_range(0, set_addrs.size() - 1)];
  endfunction

  function automatic void queue_random();
    instr_t x;
    int pick;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 22) x.op = taie_pkg::AFC;
      else if (pick < 25) x.op = OpW'($urandom_range(int'(taie_pkg::NOP) + 1, LastOp));
      else x.op = OpW'($urandom_range(int'(taie_pkg::ADD), int'(taie_pkg::NOP)));
      x.dst  = (x.op == taie_pkg::COPB) ? any_set_addr()
                                        : AddrW'($urandom_range(0, Words - 1));
      x.src1 = ($urandom_range(0, 15) == 0) ? AddrW'($urandom_range(0, Words - 1))
                                            : any_set_addr();
      x.src2 = any_set_addr();
      case ($urandom_range(0, 3))
        0: x.imm = ImmW'($urandom_range(0, Words - 1));  // usable pointer
        1: x.imm = ImmW'($urandom_range(0, 1));          // zero divisor, jump condition
        default: x.imm = $urandom();
      endcase
      x.jline = ($urandom_range(0, 7) == 0) ? stop_line
                : LineW'($urandom_range(0, taie_pkg::LineDepthDef - 1));
    end while (!reads_defined(x));
    pending_instrs.push_back(x);
    expected_outcomes.push_back(run_instr(x));
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: a new instruction is offered after the previous transfer and,
  // while idle_en is set, a random gap; valid stays up while the block stalls.
  // ---------------------------------------------------------------------------
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   send_gap = 0;
  int   recv_hold = 0;

  always @(posedge clk_i) begin
    in_fire  <= in_valid && !in_stall;
    out_fire <= out_valid && !out_stall;
  end

  always @(negedge clk_i) begin
    instr_t x;
    if (rst_ni && (!in_valid || in_fire)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_instrs.size() != 0) begin
        x = pending_instrs.pop_front();
        opcode_i          <= x.op;
        dest_addr_i       <= x.dst;
        src1_addr_i       <= x.src1;
        src2_addr_i       <= x.src2;
        immediate_value_i <= x.imm;
        jump_line_i       <= x.jline;
        in_valid          <= 1'b1;
        send_gap          <= idle_en ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random hold-off per result while idle_en is set, plus one long hold when requested.
  always @(negedge clk_i) begin
    int h;
    if (rst_ni) begin
      if (long_hold_done < long_hold_req) begin
        long_hold_done <= long_hold_done + 1;
        recv_hold <= LongHold;
        out_stall <= 1'b1;
      end else if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_stall <= 1'b1;
      end else if (out_fire && idle_en) begin
        h = $urandom_range(0, 9);
        recv_hold <= (h != 0) ? h - 1 : 0;
        out_stall <= (h != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, next_line %0d", $time, next_line_o);
      end else begin
        e = expected_outcomes.pop_front();
        if (next_line_o !== e.nline) begin
          mismatches++;
          $display("%0t: next_line exp %0d got %0d", $time, e.nline, next_line_o);
        end
        if (halted_o !== e.halt) begin
          mismatches++;
          $display("%0t: halted exp %0b got %0b", $time, e.halt, halted_o);
        end
        if (print_valid_o !== e.pvalid) begin
          mismatches++;
          $display("%0t: print_valid exp %0b got %0b", $time, e.pvalid, print_valid_o);
        end
        if (print_addr_o !== e.paddr) begin
          mismatches++;
          $display("%0t: print_addr exp %0d got %0d", $time, e.paddr, print_addr_o);
        end
        if (print_value_o !== e.pvalue) begin
          mismatches++;
          $display("%0t: print_value exp %h got %h", $time, e.pvalue, print_value_o);
        end
        if (fault_o !== e.flt) begin
          mismatches++;
          $display("%0t: fault exp %0d got %0d", $time, e.flt, fault_o);
        end
      end
    end
  end

  task automatic write_line_reg(input logic idx, input logic [LineW-1:0] val);
    @(negedge clk_i);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == taie_pkg::CfgStartLine) shadow_pc = val;
    else stop_line = val;
  endtask

  // Drain: all results back, then an idle stretch before returning.
  task automatic wait_drained();
    wait (pending_instrs.size() == 0 && expected_outcomes.size() == 0);
    repeat (3 * DataW) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [LineW-1:0] first_line [NumPhase];
    logic [LineW-1:0] last_line  [NumPhase];
    shadow_pc = '0;
    stop_line = '0;
    foreach (word_set[i]) word_set[i] = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    first_line = '{10'd1020, 10'd0, 10'd1023, 10'd512, 10'd0, 10'd1023, 10'd3, 10'd700};
    last_line  = '{10'd1023, 10'd0, 10'd1023, 10'd515, 10'd1023, 10'd0, 10'd9, 10'd0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_line_reg(taie_pkg::CfgStartLine, first_line[0]);
    write_line_reg(taie_pkg::CfgEndLine, last_line[0]);
    // Directed: word extremes, every operation, each fault, line wrap past the
    // top of the program space, halt at end line and running on after halt.
    queue_instr(taie_pkg::AFC, 0, 0, 0, 32'h7FFF_FFFF, 0);
    queue_instr(taie_pkg::AFC, 1, 0, 0, 32'h8000_0000, 0);
    queue_instr(taie_pkg::AFC, 2, 0, 0, 32'h0, 0);
    queue_instr(taie_pkg::AFC, 3, 0, 0, 32'h1, 0);
    queue_instr(taie_pkg::AFC, 4, 0, 0, 32'hFFFF_FFFF, 0);
    queue_instr(taie_pkg::AFC, 255, 0, 0, 32'h3, 0);
    queue_instr(taie_pkg::ADD, 5, 0, 3, '0, 0);
    queue_instr(taie_pkg::SUB, 6, 1, 3, '0, 0);
    queue_instr(taie_pkg::MUL, 7, 0, 4, '0, 0);
    queue_instr(taie_pkg::DIV, 8, 1, 4, '0, 0);    // most negative over minus one
    queue_instr(taie_pkg::DIV, 9, 0, 2, '0, 0);    // zero divisor
    queue_instr(taie_pkg::INF, 10, 1, 0, '0, 0);
    queue_instr(taie_pkg::EQU, 11, 3, 3, '0, 0);
    queue_instr(taie_pkg::SUP, 12, 0, 1, '0, 0);
    queue_instr(taie_pkg::AND, 13, 0, 2, '0, 0);
    queue_instr(taie_pkg::OR, 14, 2, 4, '0, 0);
    queue_instr(taie_pkg::JMF, 0, 3, 0, '0, 1000); // condition is one: falls through
    queue_instr(taie_pkg::JMF, 0, 2, 0, '0, 1023); // taken, lands on end line
    queue_instr(taie_pkg::COP, 15, 4, 0, '0, 0);
    queue_instr(taie_pkg::COPA, 16, 255, 0, '0, 0);
    queue_instr(taie_pkg::COPA, 17, 1, 0, '0, 0);  // negative pointer
    queue_instr(taie_pkg::AFC, 18, 0, 0, 32'd256, 0);
    queue_instr(taie_pkg::COPB, 18, 0, 0, '0, 0);  // pointer one past the end
    queue_instr(taie_pkg::COPB, 255, 0, 0, '0, 0);
    queue_instr(taie_pkg::PRI, 0, 255, 0, '0, 0);
    queue_instr(taie_pkg::JMP, 0, 0, 0, '0, 1023);
    queue_instr(taie_pkg::CALL, 0, 0, 0, '0, 0);
    queue_instr(taie_pkg::RET, 0, 0, 0, '0, 0);
    queue_instr(taie_pkg::NOP, 255, 255, 255, 32'hFFFF_FFFF, 1023);
    queue_instr(OpW'(LastOp), 0, 0, 0, '0, 0);     // undefined opcode
    wait_drained();

    for (int ph = 1; ph < NumPhase; ph++) begin
      write_line_reg(taie_pkg::CfgStartLine, first_line[ph]);
      write_line_reg(taie_pkg::CfgEndLine, last_line[ph]);
      idle_en = (ph != 3);                   // one phase at full rate
      if (ph == 2) long_hold_req++;          // fill the block, stall its input
      for (int n = 0; n < PerPhase; n++) queue_random();
      wait_drained();                        // sender pauses until all results are in
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/taie_pkg.sv
rtl/taie_div.sv
rtl/three_address_instruction_executor_core.sv
tb/sv/tb_three_address_instruction_executor_core.sv
